### sv/trapezoid_profile_calc_core_defines.svh
// Assertion macros for the checker file.
`ifndef TRAPEZOID_PROFILE_CALC_CORE_DEFINES_SVH
`define TRAPEZOID_PROFILE_CALC_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpc check failed");

// Next-cycle implication, disabled during reset.
`define TPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpc check failed");

`endif

### sv/tpc_pkg.sv
package tpc_pkg;

  // Field widths
  localparam int STEP_COUNT_BITS = 24;
  localparam int RATE_BITS       = 20;
  localparam int SPEED_BITS      = 24;
  localparam int INC_BITS        = 24;
  localparam int TICK_BITS       = 17;

  localparam logic [TICK_BITS-1:0] TICKS_RESET = TICK_BITS'(1000);

  // Rate increment is Q8.16; squared rates carry the same scale
  localparam int SCALE_SHIFT = 16;

  // Internal widths
  localparam int AW   = INC_BITS + TICK_BITS;            // acceleration, fixed point
  localparam int RNW  = RATE_BITS + SPEED_BITS;          // rate numerator
  localparam int SQW  = 2 * RATE_BITS;                   // squared rate
  localparam int EW   = SQW + 1;                         // signed square difference
  localparam int ADN  = SQW + SCALE_SHIFT - 1;           // accel/decel dividend
  localparam int ACW  = ADN + 2;                         // signed rounded quotient
  localparam int PW   = ACW + 2;                         // plateau arithmetic
  localparam int MPW  = AW + STEP_COUNT_BITS;            // accel times steps
  localparam int ALO  = (AW + 1) / 2;                    // low split of accel
  localparam int AHI  = AW - ALO;
  localparam int MNW  = ((MPW + 1 > SQW + SCALE_SHIFT) ? MPW + 1 : SQW + SCALE_SHIFT) + 1;
  localparam int MQ   = STEP_COUNT_BITS + 1;             // meeting quotient bits
  localparam int D4W  = AW + 2;                          // four times accel

  typedef struct packed {
    logic [STEP_COUNT_BITS-1:0] step_count;
    logic [RATE_BITS-1:0]       cruise_rate;
    logic [SPEED_BITS-1:0]      cruise_speed;
    logic [SPEED_BITS-1:0]      start_speed;
    logic [SPEED_BITS-1:0]      end_speed;
    logic [INC_BITS-1:0]        rate_increment;
    logic                       block_executing;
  } in_t;

  typedef struct packed {
    logic [RATE_BITS-1:0]       start_rate;
    logic [RATE_BITS-1:0]       end_rate;
    logic [STEP_COUNT_BITS-1:0] accel_end_step;
    logic [STEP_COUNT_BITS-1:0] decel_start_step;
    logic                       updated;
    logic                       divide_error;
  } out_t;

endpackage

### sv/trapezoid_profile_calc_core.sv
// Trapezoidal velocity profile for one motion block. One request per cycle is
// taken while the output is not stalled; its result passes, in order, through
// 4 input stages (capture, rate products, round-up bias, divider
// setup), a 20-stage radix-2 divider for the entry and exit rates, 5 stages of
// squaring and setup, a 55-stage radix-2 divider for the acceleration and
// deceleration lengths (the meeting-point divide runs in its first 25 stages),
// 2 rounding/clamp stages and the output register. A stalled output freezes the
// whole pipeline. The acceleration tick register may be written at any time the
// pipeline is empty; cfg_ready is always high.
module trapezoid_profile_calc_core import tpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TICK_BITS-1:0] cfg_data
);

  localparam int SW = STEP_COUNT_BITS;

  typedef struct packed {
    in_t           f;
    logic [AW-1:0] a;
  } s1_t;

  typedef struct packed {
    logic [SW-1:0]         steps;
    logic [RATE_BITS-1:0]  nr;
    logic [SPEED_BITS-1:0] ns;
    logic [AW-1:0]         a;
    logic                  exec;
    logic                  err;
    logic [RNW-1:0]        prod_s;
    logic [RNW-1:0]        prod_e;
  } s2_t;

  typedef struct packed {
    logic [SW-1:0]         steps;
    logic [RATE_BITS-1:0]  nr;
    logic [SPEED_BITS-1:0] ns;
    logic [AW-1:0]         a;
    logic                  exec;
    logic                  err;
    logic [RNW-1:0]        num_s;
    logic [RNW-1:0]        num_e;
  } s3_t;

  typedef struct packed {
    logic [SW-1:0]         steps;
    logic [RATE_BITS-1:0]  nr;
    logic [SPEED_BITS-1:0] ns;
    logic [AW-1:0]         a;
    logic                  exec;
    logic                  err;
    logic [RNW-1:0]        num_s;
    logic [RNW-1:0]        num_e;
    logic                  sat_s;
    logic                  sat_e;
    logic [SPEED_BITS-1:0] rem_s;
    logic [SPEED_BITS-1:0] rem_e;
    logic [RATE_BITS-1:0]  q_s;
    logic [RATE_BITS-1:0]  q_e;
  } rs_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic [RATE_BITS-1:0] nr;
    logic [AW-1:0]        a;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
  } s5_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic [AW-1:0]        a;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic [SQW-1:0]       nr2;
    logic [SQW-1:0]       sr2;
    logic [SQW-1:0]       er2;
    logic [ALO+SW-1:0]    p_lo;
    logic [AHI+SW-1:0]    p_hi;
  } s6_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic [AW-1:0]        a;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic [EW-1:0]        m_acc;
    logic [EW-1:0]        m_dec;
    logic [EW-1:0]        e_ms;
    logic [MPW-1:0]       mp;
  } s7_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic [AW-1:0]        a;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic                 acc_neg;
    logic                 dec_neg;
    logic [SQW-1:0]       acc_mag;
    logic [SQW-1:0]       dec_mag;
    logic [MNW-1:0]       m_num;
  } s8_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic [AW-1:0]        a;
    logic [D4W-1:0]       d4;
    logic                 acc_neg;
    logic                 dec_neg;
    logic [ADN-1:0]       acc_num;
    logic [ADN-1:0]       dec_num;
    logic [AW-1:0]        acc_rem;
    logic [AW-1:0]        dec_rem;
    logic [ADN-1:0]       acc_q;
    logic [ADN-1:0]       dec_q;
    logic                 m_pos;
    logic                 m_sat;
    logic [MQ-1:0]        m_lo;
    logic [D4W-1:0]       m_rem;
    logic [MQ-1:0]        m_q;
  } dv_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic [ACW-1:0]       acc;
    logic [ACW-1:0]       dec;
    logic                 m_pos;
    logic                 m_sat;
    logic [MQ:0]          m_qc;
  } f1_t;

  typedef struct packed {
    logic [SW-1:0]        steps;
    logic                 exec;
    logic                 err;
    logic [RATE_BITS-1:0] sr;
    logic [RATE_BITS-1:0] er;
    logic [ACW-1:0]       acc;
    logic                 plat_neg;
    logic [PW-1:0]        sd;
    logic [SW-1:0]        m_ae;
  } f2_t;

  logic [TICK_BITS-1:0] ticks;
  logic                 adv;

  logic v1, v2, v3, v5, v6, v7, v8, vf1, vf2, ov;
  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  s5_t  s5;
  s6_t  s6;
  s7_t  s7;
  s8_t  s8;
  f1_t  f1;
  f2_t  f2;
  out_t od;

  logic rsv [0:RATE_BITS];
  rs_t  rs  [0:RATE_BITS];
  logic dvv [0:ADN];
  dv_t  dv  [0:ADN];

  // Whole pipeline advances unless the output register is stuck
  assign adv       = !ov || out_ready;
  assign in_ready  = adv;
  assign out_valid = ov;
  assign out_data  = od;
  assign cfg_ready = 1'b1;

  // Tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= TICKS_RESET;
    end else if (cfg_valid) begin
      ticks <= cfg_data;
    end
  end

  // Valid chain outside the divider arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      rsv[0] <= 1'b0;
      v5     <= 1'b0;
      v6     <= 1'b0;
      v7     <= 1'b0;
      v8     <= 1'b0;
      dvv[0] <= 1'b0;
      vf1    <= 1'b0;
      vf2    <= 1'b0;
      ov     <= 1'b0;
    end else if (adv) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      rsv[0] <= v3;
      v5     <= rsv[RATE_BITS];
      v6     <= v5;
      v7     <= v6;
      v8     <= v7;
      dvv[0] <= v8;
      vf1    <= dvv[ADN];
      vf2    <= vf1;
      ov     <= vf2;
    end
  end

  // Stage 1: capture request, acceleration = increment * ticks
  always_ff @(posedge clk) begin
    if (adv) begin
      s1.f <= in_data;
      s1.a <= AW'(in_data.rate_increment) * AW'(ticks);
    end
  end

  // Stage 2: rate products, error flags
  always_ff @(posedge clk) begin
    if (adv) begin
      s2.steps  <= s1.f.step_count;
      s2.nr     <= s1.f.cruise_rate;
      s2.ns     <= s1.f.cruise_speed;
      s2.a      <= s1.a;
      s2.exec   <= s1.f.block_executing;
      s2.err    <= (s1.f.cruise_speed == '0) || (s1.a == '0);
      s2.prod_s <= RNW'(s1.f.cruise_rate) * RNW'(s1.f.start_speed);
      s2.prod_e <= RNW'(s1.f.cruise_rate) * RNW'(s1.f.end_speed);
    end
  end

  // Stage 3: round-up bias for the rate divide
  always_ff @(posedge clk) begin
    if (adv) begin
      s3.steps <= s2.steps;
      s3.nr    <= s2.nr;
      s3.ns    <= s2.ns;
      s3.a     <= s2.a;
      s3.exec  <= s2.exec;
      s3.err   <= s2.err;
      s3.num_s <= s2.prod_s + RNW'(s2.ns) - RNW'(1);
      s3.num_e <= s2.prod_e + RNW'(s2.ns) - RNW'(1);
    end
  end

  // Stage 4: rate divider setup; quotient past the rate range saturates
  always_ff @(posedge clk) begin
    if (adv) begin
      rs[0].steps <= s3.steps;
      rs[0].nr    <= s3.nr;
      rs[0].ns    <= s3.ns;
      rs[0].a     <= s3.a;
      rs[0].exec  <= s3.exec;
      rs[0].err   <= s3.err;
      rs[0].num_s <= s3.num_s;
      rs[0].num_e <= s3.num_e;
      rs[0].sat_s <= s3.num_s[RNW-1:RATE_BITS] >= s3.ns;
      rs[0].sat_e <= s3.num_e[RNW-1:RATE_BITS] >= s3.ns;
      rs[0].rem_s <= s3.num_s[RNW-1:RATE_BITS];
      rs[0].rem_e <= s3.num_e[RNW-1:RATE_BITS];
      rs[0].q_s   <= '0;
      rs[0].q_e   <= '0;
    end
  end

  // Rate divider: one quotient bit per stage
  for (genvar k = 0; k < RATE_BITS; k++) begin : g_rate
    rs_t                 nx;
    logic [SPEED_BITS:0] ts;
    logic [SPEED_BITS:0] te;

    always_comb begin
      nx = rs[k];
      ts = {rs[k].rem_s, rs[k].num_s[RATE_BITS-1-k]};
      te = {rs[k].rem_e, rs[k].num_e[RATE_BITS-1-k]};
      if (ts >= {1'b0, rs[k].ns}) begin
        nx.rem_s                = SPEED_BITS'(ts - {1'b0, rs[k].ns});
        nx.q_s[RATE_BITS-1-k]   = 1'b1;
      end else begin
        nx.rem_s                = ts[SPEED_BITS-1:0];
      end
      if (te >= {1'b0, rs[k].ns}) begin
        nx.rem_e                = SPEED_BITS'(te - {1'b0, rs[k].ns});
        nx.q_e[RATE_BITS-1-k]   = 1'b1;
      end else begin
        nx.rem_e                = te[SPEED_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rsv[k+1] <= 1'b0;
      end else if (adv) begin
        rsv[k+1] <= rsv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rs[k+1] <= nx;
      end
    end
  end

  // Stage 5: saturated start and end rates
  always_ff @(posedge clk) begin
    if (adv) begin
      s5.steps <= rs[RATE_BITS].steps;
      s5.nr    <= rs[RATE_BITS].nr;
      s5.a     <= rs[RATE_BITS].a;
      s5.exec  <= rs[RATE_BITS].exec;
      s5.err   <= rs[RATE_BITS].err;
      s5.sr    <= rs[RATE_BITS].sat_s ? '1 : rs[RATE_BITS].q_s;
      s5.er    <= rs[RATE_BITS].sat_e ? '1 : rs[RATE_BITS].q_e;
    end
  end

  // Stage 6: squares and split accel * steps products
  always_ff @(posedge clk) begin
    if (adv) begin
      s6.steps <= s5.steps;
      s6.a     <= s5.a;
      s6.exec  <= s5.exec;
      s6.err   <= s5.err;
      s6.sr    <= s5.sr;
      s6.er    <= s5.er;
      s6.nr2   <= SQW'(s5.nr) * SQW'(s5.nr);
      s6.sr2   <= SQW'(s5.sr) * SQW'(s5.sr);
      s6.er2   <= SQW'(s5.er) * SQW'(s5.er);
      s6.p_lo  <= (ALO+SW)'(s5.a[ALO-1:0]) * (ALO+SW)'(s5.steps);
      s6.p_hi  <= (AHI+SW)'(s5.a[AW-1:ALO]) * (AHI+SW)'(s5.steps);
    end
  end

  // Stage 7: square differences, recombine product
  always_ff @(posedge clk) begin
    if (adv) begin
      s7.steps <= s6.steps;
      s7.a     <= s6.a;
      s7.exec  <= s6.exec;
      s7.err   <= s6.err;
      s7.sr    <= s6.sr;
      s7.er    <= s6.er;
      s7.m_acc <= {1'b0, s6.nr2} - {1'b0, s6.sr2};
      s7.m_dec <= {1'b0, s6.nr2} - {1'b0, s6.er2};
      s7.e_ms  <= {1'b0, s6.er2} - {1'b0, s6.sr2};
      s7.mp    <= {s6.p_hi, {ALO{1'b0}}} + MPW'(s6.p_lo);
    end
  end

  // Stage 8: magnitudes, meeting-point dividend
  logic [MNW-1:0] e_ext;

  always_comb begin
    e_ext = {{(MNW-EW-SCALE_SHIFT){s7.e_ms[EW-1]}}, s7.e_ms, {SCALE_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8.steps   <= s7.steps;
      s8.a       <= s7.a;
      s8.exec    <= s7.exec;
      s8.err     <= s7.err;
      s8.sr      <= s7.sr;
      s8.er      <= s7.er;
      s8.acc_neg <= s7.m_acc[EW-1];
      s8.dec_neg <= s7.m_dec[EW-1];
      s8.acc_mag <= s7.m_acc[EW-1] ? SQW'(-s7.m_acc) : SQW'(s7.m_acc);
      s8.dec_mag <= s7.m_dec[EW-1] ? SQW'(-s7.m_dec) : SQW'(s7.m_dec);
      s8.m_num   <= MNW'({s7.mp, 1'b0}) + e_ext;
    end
  end

  // Stage 9: main divider setup
  logic [D4W-1:0] d4_w;
  logic [D4W-1:0] m_hi_w;

  always_comb begin
    d4_w   = {s8.a, 2'b00};
    m_hi_w = D4W'(s8.m_num[MNW-2:MQ]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].steps   <= s8.steps;
      dv[0].exec    <= s8.exec;
      dv[0].err     <= s8.err;
      dv[0].sr      <= s8.sr;
      dv[0].er      <= s8.er;
      dv[0].a       <= s8.a;
      dv[0].d4      <= d4_w;
      dv[0].acc_neg <= s8.acc_neg;
      dv[0].dec_neg <= s8.dec_neg;
      dv[0].acc_num <= {s8.acc_mag, {(SCALE_SHIFT-1){1'b0}}};
      dv[0].dec_num <= {s8.dec_mag, {(SCALE_SHIFT-1){1'b0}}};
      dv[0].acc_rem <= '0;
      dv[0].dec_rem <= '0;
      dv[0].acc_q   <= '0;
      dv[0].dec_q   <= '0;
      dv[0].m_pos   <= !s8.m_num[MNW-1] && (s8.m_num != '0);
      dv[0].m_sat   <= m_hi_w >= d4_w;
      dv[0].m_lo    <= s8.m_num[MQ-1:0];
      dv[0].m_rem   <= m_hi_w;
      dv[0].m_q     <= '0;
    end
  end

  // Main divider: accel and decel lengths, meeting point in the first stages
  for (genvar k = 0; k < ADN; k++) begin : g_div
    dv_t            nx;
    logic [AW:0]    ta;
    logic [AW:0]    td;
    logic [D4W-1:0] m_rem_n;
    logic [MQ-1:0]  m_q_n;

    if (k < MQ) begin : g_meet
      logic [D4W:0] tm;
      always_comb begin
        tm      = {dv[k].m_rem, dv[k].m_lo[MQ-1-k]};
        m_q_n   = dv[k].m_q;
        if (tm >= {1'b0, dv[k].d4}) begin
          m_rem_n          = D4W'(tm - {1'b0, dv[k].d4});
          m_q_n[MQ-1-k]    = 1'b1;
        end else begin
          m_rem_n          = tm[D4W-1:0];
        end
      end
    end else begin : g_hold
      assign m_rem_n = dv[k].m_rem;
      assign m_q_n   = dv[k].m_q;
    end

    always_comb begin
      nx = dv[k];
      ta = {dv[k].acc_rem, dv[k].acc_num[ADN-1-k]};
      td = {dv[k].dec_rem, dv[k].dec_num[ADN-1-k]};
      if (ta >= {1'b0, dv[k].a}) begin
        nx.acc_rem          = AW'(ta - {1'b0, dv[k].a});
        nx.acc_q[ADN-1-k]   = 1'b1;
      end else begin
        nx.acc_rem          = ta[AW-1:0];
      end
      if (td >= {1'b0, dv[k].a}) begin
        nx.dec_rem          = AW'(td - {1'b0, dv[k].a});
        nx.dec_q[ADN-1-k]   = 1'b1;
      end else begin
        nx.dec_rem          = td[AW-1:0];
      end
      nx.m_rem = m_rem_n;
      nx.m_q   = m_q_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= nx;
      end
    end
  end

  // F1: signed rounding, ceil for accel, floor for decel
  logic [ACW-1:0] acc_q_w;
  logic [ACW-1:0] dec_q_w;
  logic [ACW-1:0] acc_n;
  logic [ACW-1:0] dec_n;

  always_comb begin
    acc_q_w = ACW'(dv[ADN].acc_q);
    dec_q_w = ACW'(dv[ADN].dec_q) + ACW'(dv[ADN].dec_rem != '0);
    acc_n   = dv[ADN].acc_neg ? -acc_q_w : acc_q_w + ACW'(dv[ADN].acc_rem != '0);
    dec_n   = dv[ADN].dec_neg ? -dec_q_w : ACW'(dv[ADN].dec_q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1.steps <= dv[ADN].steps;
      f1.exec  <= dv[ADN].exec;
      f1.err   <= dv[ADN].err;
      f1.sr    <= dv[ADN].sr;
      f1.er    <= dv[ADN].er;
      f1.acc   <= acc_n;
      f1.dec   <= dec_n;
      f1.m_pos <= dv[ADN].m_pos;
      f1.m_sat <= dv[ADN].m_sat;
      f1.m_qc  <= (MQ+1)'(dv[ADN].m_q) + (MQ+1)'(dv[ADN].m_rem != '0);
    end
  end

  // F2: plateau sign, decel start before clamp, clamped meeting point
  logic [PW-1:0] acc_x;
  logic [PW-1:0] dec_x;
  logic [PW-1:0] plat;
  logic [SW-1:0] m_ae_n;

  always_comb begin
    acc_x = {{(PW-ACW){f1.acc[ACW-1]}}, f1.acc};
    dec_x = {{(PW-ACW){f1.dec[ACW-1]}}, f1.dec};
    plat  = PW'(f1.steps) - acc_x - dec_x;
    if (!f1.m_pos) begin
      m_ae_n = '0;
    end else if (f1.m_sat || (f1.m_qc > (MQ+1)'(f1.steps))) begin
      m_ae_n = f1.steps;
    end else begin
      m_ae_n = f1.m_qc[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2.steps    <= f1.steps;
      f2.exec     <= f1.exec;
      f2.err      <= f1.err;
      f2.sr       <= f1.sr;
      f2.er       <= f1.er;
      f2.acc      <= f1.acc;
      f2.plat_neg <= plat[PW-1];
      f2.sd       <= PW'(f1.steps) - dec_x;
      f2.m_ae     <= m_ae_n;
    end
  end

  // Output: clamp to 0..steps, pick meeting point on overlap, apply flags
  logic [SW-1:0] ae_c;
  logic [SW-1:0] ds_c;
  out_t          od_next;

  always_comb begin
    if (f2.acc[ACW-1]) begin
      ae_c = '0;
    end else if (f2.acc > ACW'(f2.steps)) begin
      ae_c = f2.steps;
    end else begin
      ae_c = f2.acc[SW-1:0];
    end
    if (f2.sd[PW-1]) begin
      ds_c = '0;
    end else if (f2.sd > PW'(f2.steps)) begin
      ds_c = f2.steps;
    end else begin
      ds_c = f2.sd[SW-1:0];
    end

    od_next = '0;
    if (!f2.exec) begin
      od_next.updated = 1'b1;
      if (f2.err) begin
        od_next.divide_error = 1'b1;
      end else begin
        od_next.start_rate       = f2.sr;
        od_next.end_rate         = f2.er;
        od_next.accel_end_step   = f2.plat_neg ? f2.m_ae : ae_c;
        od_next.decel_start_step = f2.plat_neg ? f2.m_ae : ds_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od <= od_next;
    end
  end

endmodule

### sv/tpc_checker.sv
`include "trapezoid_profile_calc_core_defines.svh"

module tpc_checker import tpc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Stalled result holds
  `TPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Empty output never blocks the input
  `TPC_ASSERT_IMP(a_ready_empty, !out_valid, in_ready)

  // Skipped block gives an all-zero result
  `TPC_ASSERT_IMP(a_skip_zero, out_valid && !out_data.updated, (out_data.start_rate == '0) && (out_data.end_rate == '0) && (out_data.accel_end_step == '0) && (out_data.decel_start_step == '0) && !out_data.divide_error)

  // Deceleration never starts before acceleration ends
  `TPC_ASSERT_IMP(a_step_order, out_valid, out_data.decel_start_step >= out_data.accel_end_step)

endmodule

bind trapezoid_profile_calc_core tpc_checker u_tpc_checker (.*);
